[rtl/msort_pkg.sv]
// Shared types and constants for the merge sorter block.
`timescale 1ns / 1ps
`default_nettype none

package msort_pkg;

  // Width of one stored element.
  localparam int DATA_W = 32;

  // One input item: an element of the run and the end-of-run flag.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  // One result item: the next sorted element and its end-of-run flags.
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     dropped;
  } out_item_t;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_GSET  = 7'b0000010,
    S_MRD   = 7'b0000100,
    S_MWR   = 7'b0001000,
    S_DRD   = 7'b0010000,
    S_DLD   = 7'b0100000,
    S_DWAIT = 7'b1000000
  } msort_state_t;

endpackage

`default_nettype wire

[rtl/merge_sorter_unit.sv]
// Top level of the merge sorter: run buffer, merge sequencer and result register.
//
//   Channel | Direction | Payload     | Handshake
//   in_     | input     | in_item_t   | in_valid / in_stall
//   out_    | output    | out_item_t  | out_valid / out_stall
//
// Loading takes one cycle per item. After the last item, the sort runs
// ceil(log2(n)) passes over two ping-pong RAMs; each pass sets up each group's
// bounds, then per element reads both heads, then compares and writes.
// Each result drains through a registered RAM read, a load and a wait until taken.
// Reset is synchronous and active low and empties the run buffer.
// A stalled result holds its value; no item is accepted while a run sorts or drains.
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter_unit
  import msort_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = CW + 2;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  msort_state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          src_r, src_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic                     acc_in;
  logic                     store_ok;
  logic [CW-1:0]            fill_inc;
  logic [CW-1:0]            n_new;
  logic [WW-1:0]            mid_w;
  logic [WW-1:0]            hi_w;
  logic [CW:0]              w2;
  logic [CW-1:0]            k_inc;
  logic                     i_ok;
  logic                     j_ok;
  logic                     take_left;
  logic [DATA_W-1:0]        head_l;
  logic [DATA_W-1:0]        head_r;
  logic [DATA_W-1:0]        mdata;
  logic                     is_final;

  logic              a_we, b_we;
  logic [AW-1:0]     a_waddr;
  logic [DATA_W-1:0] a_wdata;
  logic [AW-1:0]     rd_addr0, rd_addr1;
  logic [DATA_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;

  // Handshake and load bookkeeping.
  assign in_stall  = (state_r != S_LOAD);
  assign acc_in    = in_valid && !in_stall;
  assign store_ok  = (fill_r < CAP_C);
  assign fill_inc  = fill_r + CW'(1);
  assign n_new     = store_ok ? fill_inc : fill_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Group bounds for the current merge width, clamped to the run length.
  assign mid_w = WW'(lo_r) + WW'(w_r);
  assign hi_w  = mid_w + WW'(w_r);
  assign w2    = {w_r, 1'b0};
  assign k_inc = k_r + CW'(1);

  // Merge compare: take the left head while it exists and is not greater.
  assign head_l    = src_r ? b_rd0 : a_rd0;
  assign head_r    = src_r ? b_rd1 : a_rd1;
  assign i_ok      = (i_r < mid_r);
  assign j_ok      = (j_r < hi_r);
  assign take_left = i_ok && (!j_ok || ($signed(head_l) <= $signed(head_r)));
  assign mdata     = take_left ? head_l : head_r;
  assign is_final  = (k_inc == n_r);

  // RAM ports: A is loaded directly; merges write whichever buffer is the destination.
  assign a_we     = (acc_in && store_ok) || ((state_r == S_MWR) && src_r);
  assign a_waddr  = (state_r == S_LOAD) ? fill_r[AW-1:0] : k_r[AW-1:0];
  assign a_wdata  = (state_r == S_LOAD) ? in_data.value : mdata;
  assign b_we     = (state_r == S_MWR) && !src_r;
  assign rd_addr0 = (state_r == S_DRD) ? k_r[AW-1:0] : i_r[AW-1:0];
  assign rd_addr1 = j_r[AW-1:0];

  msort_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr0(rd_addr0),
    .raddr1(rd_addr1),
    .rdata0(a_rd0),
    .rdata1(a_rd1)
  );

  msort_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (k_r[AW-1:0]),
    .wdata (mdata),
    .raddr0(rd_addr0),
    .raddr1(rd_addr1),
    .rdata0(b_rd0),
    .rdata1(b_rd1)
  );

  // Sequencer: load, merge passes, then drain.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    w_nxt         = w_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    src_nxt       = src_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    unique case (state_r)
      S_LOAD: begin
        if (acc_in) begin
          fill_nxt = n_new;
          ovf_nxt  = ovf_r | !store_ok;
          if (in_data.last) begin
            n_nxt   = n_new;
            src_nxt = 1'b0;
            w_nxt   = CW'(1);
            lo_nxt  = '0;
            k_nxt   = '0;
            // A run of one element needs no merging.
            state_nxt = (n_new == CW'(1)) ? S_DRD : S_GSET;
          end
        end
      end
      S_GSET: begin
        mid_nxt   = (mid_w > WW'(n_r)) ? n_r : mid_w[CW-1:0];
        hi_nxt    = (hi_w > WW'(n_r)) ? n_r : hi_w[CW-1:0];
        i_nxt     = lo_r;
        j_nxt     = (mid_w > WW'(n_r)) ? n_r : mid_w[CW-1:0];
        k_nxt     = lo_r;
        state_nxt = S_MRD;
      end
      S_MRD: begin
        state_nxt = S_MWR;
      end
      S_MWR: begin
        if (take_left) begin
          i_nxt = i_r + CW'(1);
        end else begin
          j_nxt = j_r + CW'(1);
        end
        k_nxt     = k_inc;
        state_nxt = S_MRD;
        if (k_inc == hi_r) begin
          if (hi_r == n_r) begin
            // End of a pass: the destination becomes the next source.
            src_nxt = !src_r;
            lo_nxt  = '0;
            if (w2 >= (CW+1)'(n_r)) begin
              k_nxt     = '0;
              state_nxt = S_DRD;
            end else begin
              w_nxt     = w2[CW-1:0];
              state_nxt = S_GSET;
            end
          end else begin
            lo_nxt    = hi_r;
            state_nxt = S_GSET;
          end
        end
      end
      S_DRD: begin
        state_nxt = S_DLD;
      end
      S_DLD: begin
        out_nxt.sorted_value = src_r ? b_rd0 : a_rd0;
        out_nxt.final_res    = is_final;
        out_nxt.dropped      = is_final && ovf_r;
        out_valid_nxt        = 1'b1;
        state_nxt            = S_DWAIT;
      end
      S_DWAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (is_final) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_DRD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pointers and result payload.
  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    w_r   <= w_nxt;
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    src_r <= src_nxt;
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

[rtl/msort_ram.sv]
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

[rtl/msort_checker.sv]
// Port-level checks for the merge sorter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module msort_checker
  import msort_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // No item is taken while a result is pending.
  a_no_load_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while draining");

  // The overflow flag only rides on the last result of a run.
  a_drop_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped |-> out_data.final_res)
    else $error("dropped flag on a non-final result");

  // An accepted end-of-run item closes the input side on the next cycle.
  a_close_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("input still open after end of run");

endmodule

bind merge_sorter_unit msort_checker u_msort_checker (.*);

`default_nettype wire
